[rtl/arpc_pkg.sv]
// Shared types and constants of the ARP neighbour cache.
// Used by every file of the block; depends on nothing.

package arpc_pkg;

	localparam int CACHE_ENTRIES_DEF = 16;
	localparam int IP_W = 32;
	localparam int MAC_W = 48;
	localparam int CFG_W = 48;
	localparam int CFG_IDX_W = 2;
	localparam int QUEUE_DEPTH = 2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_LOCAL_ADDR = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SUBNET_MASK = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ROUTER_MAC = 2'd2;

	// request action codes
	localparam logic ACT_LOOKUP = 1'b0;
	localparam logic ACT_LEARN = 1'b1;

	typedef enum logic [1:0] {
		OP_LOOKUP = 2'd0,
		OP_ROUTER = 2'd1,
		OP_LEARN = 2'd2
	} op_t;

	typedef struct packed {
		op_t op;
		logic [IP_W-1:0] ip;
		logic [MAC_W-1:0] mac;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	typedef struct packed {
		logic hit;
		logic [MAC_W-1:0] mac_out;
		logic via_router;
		logic request_needed;
	} result_t;

endpackage

[rtl/arpc_req_if.sv]
// Request channel of the ARP neighbour cache: valid/ready plus one request.
// Depends on arpc_pkg.

interface arpc_req_if;
	logic valid;
	logic ready;
	logic action;
	logic [arpc_pkg::IP_W-1:0] ip_addr;
	logic [arpc_pkg::MAC_W-1:0] mac_addr;

	modport source (output valid, action, ip_addr, mac_addr, input ready);
	modport sink (input valid, action, ip_addr, mac_addr, output ready);
endinterface

[rtl/arpc_rsp_if.sv]
// Result channel of the ARP neighbour cache: valid/ready plus one result.
// Depends on arpc_pkg.

interface arpc_rsp_if;
	logic valid;
	logic ready;
	logic hit;
	logic [arpc_pkg::MAC_W-1:0] mac_out;
	logic via_router;
	logic request_needed;

	modport source (output valid, hit, mac_out, via_router, request_needed, input ready);
	modport sink (input valid, hit, mac_out, via_router, request_needed, output ready);
endinterface

[rtl/arpc_front.sv]
// Front end: configuration registers, request accept and subnet classification.
// Depends on arpc_pkg and arpc_req_if.

module arpc_front (
	input  logic                           clk,
	input  logic                           arst_n,
	arpc_req_if.sink                       req,
	input  logic                           cfg_we,
	input  logic [arpc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [arpc_pkg::CFG_W-1:0]     cfg_wdata,
	input  arpc_pkg::q_stat_t              q_stat,
	output logic                           push,
	output arpc_pkg::job_t                 push_data
);

	logic [arpc_pkg::IP_W-1:0]  local_addr_q;
	logic [arpc_pkg::IP_W-1:0]  subnet_mask_q;
	logic [arpc_pkg::MAC_W-1:0] router_mac_q;
	logic                       off_net;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			local_addr_q <= '0;
			subnet_mask_q <= '0;
			router_mac_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				arpc_pkg::REG_LOCAL_ADDR: local_addr_q <= cfg_wdata[arpc_pkg::IP_W-1:0];
				arpc_pkg::REG_SUBNET_MASK: subnet_mask_q <= cfg_wdata[arpc_pkg::IP_W-1:0];
				arpc_pkg::REG_ROUTER_MAC: router_mac_q <= cfg_wdata[arpc_pkg::MAC_W-1:0];
				default: ;
			endcase
		end
	end

	assign req.ready = !q_stat.full;
	assign push = req.valid && !q_stat.full;
	assign off_net = (req.ip_addr & subnet_mask_q) != (local_addr_q & subnet_mask_q);

	always_comb begin
		push_data.ip = req.ip_addr;
		push_data.mac = req.mac_addr;
		if (req.action == arpc_pkg::ACT_LEARN) begin
			push_data.op = arpc_pkg::OP_LEARN;
		end else if (off_net) begin
			// answer is fixed now: carry the router MAC down the queue
			push_data.op = arpc_pkg::OP_ROUTER;
			push_data.mac = router_mac_q;
		end else begin
			push_data.op = arpc_pkg::OP_LOOKUP;
		end
	end

endmodule

[rtl/arpc_queue.sv]
// Short job queue between front end and cache engine.
// Depends on arpc_pkg.

module arpc_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  arpc_pkg::job_t    push_data,
	input  logic              pop,
	output arpc_pkg::job_t    pop_data,
	output arpc_pkg::q_stat_t stat
);

	localparam int PTR_W = $clog2(arpc_pkg::QUEUE_DEPTH);
	localparam int CNT_W = $clog2(arpc_pkg::QUEUE_DEPTH + 1);

	arpc_pkg::job_t     slot_q [arpc_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   cnt_q;

	assign stat.full = cnt_q == CNT_W'(arpc_pkg::QUEUE_DEPTH);
	assign stat.empty = cnt_q == '0;
	assign pop_data = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(arpc_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(arpc_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

[rtl/arpc_back.sv]
// Cache engine: entry memory, valid bits and ages, scan sequencer, result register.
// Depends on arpc_pkg and arpc_rsp_if.

module arpc_back #(
	parameter int CACHE_ENTRIES = arpc_pkg::CACHE_ENTRIES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  arpc_pkg::q_stat_t q_stat,
	input  arpc_pkg::job_t    pop_data,
	output logic              pop,
	arpc_rsp_if.source        rsp
);

	localparam int IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
	localparam int AGE_W = IDX_W;
	localparam int CNT_W = $clog2(CACHE_ENTRIES + 1);
	localparam int ENT_W = arpc_pkg::IP_W + arpc_pkg::MAC_W;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_FINISH = 3'b100
	} state_t;

	state_t                     state_q;
	arpc_pkg::job_t             job_q;
	logic [ENT_W-1:0]           mem_q [CACHE_ENTRIES];
	logic [ENT_W-1:0]           rd_data_s1;
	logic                       rd_vld_s1;
	logic [IDX_W-1:0]           rd_idx_s1;
	logic [IDX_W-1:0]           iss_q;
	logic                       iss_done_q;
	logic [CACHE_ENTRIES-1:0]   valid_q;
	logic [AGE_W-1:0]           age_q [CACHE_ENTRIES];
	logic [CNT_W-1:0]           count_q;
	logic                       found_q;
	logic [arpc_pkg::MAC_W-1:0] fmac_q;
	logic                       slot_found_q;
	logic [IDX_W-1:0]           slot_q;
	logic [IDX_W-1:0]           old_q;
	logic                       out_vld_q;
	arpc_pkg::result_t          res_q;

	logic [arpc_pkg::IP_W-1:0]  rd_ip;
	logic [arpc_pkg::MAC_W-1:0] rd_mac;
	logic                       cur_v;
	logic [AGE_W-1:0]           cur_age;
	logic                       scan_act;
	logic                       is_learn;
	logic                       drop;
	logic                       take_hit;
	logic                       take_slot;
	logic                       full;
	logic [IDX_W-1:0]           ins_idx;
	logic                       out_free;
	logic                       commit;
	arpc_pkg::result_t          res_d;

	assign rd_ip = rd_data_s1[ENT_W-1:arpc_pkg::MAC_W];
	assign rd_mac = rd_data_s1[arpc_pkg::MAC_W-1:0];
	assign cur_v = valid_q[rd_idx_s1];
	assign cur_age = age_q[rd_idx_s1];
	assign is_learn = job_q.op == arpc_pkg::OP_LEARN;
	assign scan_act = (state_q == ST_SCAN) && rd_vld_s1;
	assign drop = scan_act && is_learn && cur_v
		&& (rd_ip == job_q.ip || rd_mac == job_q.mac);
	assign take_hit = scan_act && (job_q.op == arpc_pkg::OP_LOOKUP) && cur_v
		&& (rd_ip == job_q.ip) && !found_q;
	// first entry left empty after its own drop check is the insert slot
	assign take_slot = scan_act && !(cur_v && !drop) && !slot_found_q;
	assign full = count_q == CNT_W'(CACHE_ENTRIES);
	assign ins_idx = full ? old_q : slot_q;
	assign out_free = !out_vld_q || rsp.ready;
	assign commit = (state_q == ST_FINISH) && out_free;
	assign pop = (state_q == ST_IDLE) && !q_stat.empty;

	always_comb begin
		res_d = '0;
		case (job_q.op)
			arpc_pkg::OP_ROUTER: begin
				res_d.hit = 1'b1;
				res_d.mac_out = job_q.mac;
				res_d.via_router = 1'b1;
			end
			arpc_pkg::OP_LOOKUP: begin
				res_d.hit = found_q;
				res_d.mac_out = found_q ? fmac_q : '0;
				res_d.request_needed = !found_q;
			end
			default: ;
		endcase
	end

	// entry memory: one write at insert, one registered read per cycle
	always_ff @(posedge clk) begin
		if (commit && is_learn) begin
			mem_q[ins_idx] <= {job_q.ip, job_q.mac};
		end
		rd_data_s1 <= mem_q[iss_q];
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			job_q <= pop_data;
		end
		if (take_hit) begin
			fmac_q <= rd_mac;
		end
		if (take_slot) begin
			slot_q <= rd_idx_s1;
		end
		if (scan_act && cur_v && cur_age == AGE_W'(CACHE_ENTRIES - 1)) begin
			old_q <= rd_idx_s1;
		end
		if (commit) begin
			res_q <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			iss_q <= '0;
			iss_done_q <= 1'b0;
			rd_vld_s1 <= 1'b0;
			rd_idx_s1 <= '0;
			valid_q <= '0;
			for (int k = 0; k < CACHE_ENTRIES; k++) begin
				age_q[k] <= '0;
			end
			count_q <= '0;
			found_q <= 1'b0;
			slot_found_q <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (commit) begin
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (pop) begin
						iss_q <= '0;
						iss_done_q <= 1'b0;
						rd_vld_s1 <= 1'b0;
						found_q <= 1'b0;
						slot_found_q <= 1'b0;
						state_q <= (pop_data.op == arpc_pkg::OP_ROUTER) ? ST_FINISH : ST_SCAN;
					end
				end
				ST_SCAN: begin
					rd_vld_s1 <= !iss_done_q;
					rd_idx_s1 <= iss_q;
					if (!iss_done_q) begin
						iss_q <= iss_q + 1'b1;
						if (iss_q == IDX_W'(CACHE_ENTRIES - 1)) begin
							iss_done_q <= 1'b1;
						end
					end
					if (take_hit) begin
						found_q <= 1'b1;
					end
					if (take_slot) begin
						slot_found_q <= 1'b1;
					end
					if (drop) begin
						// drop entry, close the age gap it leaves
						valid_q[rd_idx_s1] <= 1'b0;
						count_q <= count_q - 1'b1;
						for (int k = 0; k < CACHE_ENTRIES; k++) begin
							if (valid_q[k] && age_q[k] > cur_age) begin
								age_q[k] <= age_q[k] - 1'b1;
							end
						end
					end
					if (scan_act && rd_idx_s1 == IDX_W'(CACHE_ENTRIES - 1)) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (commit) begin
						state_q <= ST_IDLE;
						if (is_learn) begin
							// full table: the oldest entry is replaced in place
							for (int k = 0; k < CACHE_ENTRIES; k++) begin
								if (IDX_W'(k) == ins_idx) begin
									age_q[k] <= '0;
								end else if (valid_q[k]) begin
									age_q[k] <= age_q[k] + 1'b1;
								end
							end
							valid_q[ins_idx] <= 1'b1;
							if (!full) begin
								count_q <= count_q + 1'b1;
							end
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign rsp.valid = out_vld_q;
	assign rsp.hit = res_q.hit;
	assign rsp.mac_out = res_q.mac_out;
	assign rsp.via_router = res_q.via_router;
	assign rsp.request_needed = res_q.request_needed;

endmodule

[rtl/arp_neighbour_cache_core.sv]
// ARP neighbour cache, top level: front end, job queue and cache engine.
// Depends on arpc_pkg, arpc_req_if, arpc_rsp_if, arpc_front, arpc_queue, arpc_back.
//
// Usage:
//   req  - request channel (valid/ready). action 0 looks up the next-hop MAC of
//          ip_addr, action 1 learns the pair ip_addr/mac_addr.
//   rsp  - result channel (valid/ready), exactly one result per request, in
//          request order. A learn answers with all fields zero.
//   cfg  - plain write port: cfg_we, cfg_index (0 local address, 1 subnet
//          mask, 2 router MAC), cfg_wdata. Write only while the block is idle.
// Requests are classified against the subnet when accepted and parked in a
// two-entry queue, so req stays ready while the engine is busy or the result
// register waits, until two requests wait in the queue. Off-subnet lookups
// skip the scan and go straight to the final step. Lookups and learns scan
// every entry through the entry memory, one read per cycle on the single
// memory read port. The engine takes the next request only when the last one
// has been committed to the result register.
// Reset clears the valid bits, ages and registers at once; no clearing pass.
// When rsp stalls the result holds, the engine waits in its final step and the
// queue keeps accepting until full.

module arp_neighbour_cache_core #(
	parameter int CACHE_ENTRIES = arpc_pkg::CACHE_ENTRIES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	arpc_req_if.sink                       req,
	arpc_rsp_if.source                     rsp,
	input  logic                           cfg_we,
	input  logic [arpc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [arpc_pkg::CFG_W-1:0]     cfg_wdata
);

	arpc_pkg::q_stat_t q_stat;
	arpc_pkg::job_t    push_data;
	arpc_pkg::job_t    pop_data;
	logic              push;
	logic              pop;

	// accept and classify requests, hold configuration
	arpc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.q_stat    (q_stat),
		.push      (push),
		.push_data (push_data)
	);

	// decouple front end from the scan engine
	arpc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.stat      (q_stat)
	);

	// scan the table, update it and drive the result register
	arpc_back #(
		.CACHE_ENTRIES (CACHE_ENTRIES)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_stat   (q_stat),
		.pop_data (pop_data),
		.pop      (pop),
		.rsp      (rsp)
	);

	// router answers are always hits with no request
	a_router_is_hit: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.via_router |-> rsp.hit && !rsp.request_needed)
		else $error("router result without hit");

	// a miss carries no MAC
	a_miss_no_mac: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.hit |-> rsp.mac_out == '0 && !rsp.via_router)
		else $error("miss or learn result carries data");

	// request-needed never comes with a hit
	a_req_on_miss: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.request_needed |-> !rsp.hit)
		else $error("request flagged on a hit");

	// the engine pops only a filled queue
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_stat.empty)
		else $error("pop from empty queue");

endmodule

[tb/arp_neighbour_cache_core_tb.sv]
// Self-checking testbench of the ARP neighbour cache core.
// Drives requests and configuration writes, predicts every result from a model of
// the cache kept here. Depends on arpc_pkg, arpc_req_if, arpc_rsp_if and the core.

`timescale 1ns / 1ps

module arp_neighbour_cache_core_tb;

	localparam int ENTRIES = arpc_pkg::CACHE_ENTRIES_DEF;
	// long enough to cover the worst request latency
	localparam int DRAIN_CYCLES = 2 * ENTRIES + 8;
	localparam int HOLD_CYCLES = 300;
	localparam logic [arpc_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [arpc_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [arpc_pkg::CFG_W-1:0] cfg_wdata;

	arpc_req_if req_ch ();
	arpc_rsp_if rsp_ch ();

	arp_neighbour_cache_core #(
		.CACHE_ENTRIES(ENTRIES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	// Neighbour table and registers as the core should hold them.
	logic nb_valid [ENTRIES];
	logic [arpc_pkg::IP_W-1:0] nb_ip [ENTRIES];
	logic [arpc_pkg::MAC_W-1:0] nb_mac [ENTRIES];
	int nb_age [ENTRIES];
	logic [arpc_pkg::IP_W-1:0] nb_local;
	logic [arpc_pkg::IP_W-1:0] nb_mask;
	logic [arpc_pkg::MAC_W-1:0] nb_router;

	// Results still owed by the core, oldest first.
	arpc_pkg::result_t pending_results [$];

	int mismatch_count;
	int tx_idle_pct;
	int rx_stall_pct;
	int hold_token;
	int hold_taken;
	int hold_left;

	// Clock: 4 ns period.
	initial clk = 1'b0;
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Remove one entry and close the gap it leaves in the age order.
	function automatic void drop_entry(int k);
		int a = nb_age[k];
		nb_valid[k] = 1'b0;
		nb_ip[k] = '0;
		nb_mac[k] = '0;
		nb_age[k] = 0;
		for (int i = 0; i < ENTRIES; i++) begin
			if (nb_valid[i] && nb_age[i] > a)
				nb_age[i]--;
		end
	endfunction

	// Work out the result of one accepted request and advance the table.
	function automatic arpc_pkg::result_t predict_request(input logic act,
			input logic [arpc_pkg::IP_W-1:0] ip, input logic [arpc_pkg::MAC_W-1:0] mac);
		arpc_pkg::result_t r;
		int used;
		int oldest;
		int slot;
		r = '0;
		if (act == arpc_pkg::ACT_LEARN) begin
			// drop every entry that shares the IP or the MAC
			for (int i = 0; i < ENTRIES; i++) begin
				if (nb_valid[i] && (nb_ip[i] == ip || nb_mac[i] == mac))
					drop_entry(i);
			end
			used = 0;
			for (int i = 0; i < ENTRIES; i++)
				if (nb_valid[i])
					used++;
			// full table: evict the oldest
			if (used >= ENTRIES) begin
				oldest = -1;
				for (int i = 0; i < ENTRIES; i++) begin
					if (nb_valid[i] && (oldest < 0 || nb_age[i] > nb_age[oldest]))
						oldest = i;
				end
				drop_entry(oldest);
			end
			// age the survivors, insert into the lowest free slot
			slot = -1;
			for (int i = 0; i < ENTRIES; i++) begin
				if (nb_valid[i])
					nb_age[i]++;
				else if (slot < 0)
					slot = i;
			end
			nb_valid[slot] = 1'b1;
			nb_ip[slot] = ip;
			nb_mac[slot] = mac;
			nb_age[slot] = 0;
		end else if ((nb_mask & ip) != (nb_local & nb_mask)) begin
			r.hit = 1'b1;
			r.mac_out = nb_router;
			r.via_router = 1'b1;
		end else begin
			r.request_needed = 1'b1;
			for (int i = 0; i < ENTRIES; i++) begin
				if (nb_valid[i] && nb_ip[i] == ip && r.request_needed) begin
					r.hit = 1'b1;
					r.mac_out = nb_mac[i];
					r.request_needed = 1'b0;
				end
			end
		end
		return r;
	endfunction

	// Result side: check every result taken against the oldest expectation.
	always @(posedge clk) begin
		if (rsp_ch.valid && rsp_ch.ready) begin
			if (pending_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("%0t: result with none expected: hit=%b mac=%h via=%b req=%b",
						$realtime, rsp_ch.hit, rsp_ch.mac_out, rsp_ch.via_router,
						rsp_ch.request_needed);
			end else begin
				if (rsp_ch.hit !== pending_results[0].hit
						|| rsp_ch.mac_out !== pending_results[0].mac_out
						|| rsp_ch.via_router !== pending_results[0].via_router
						|| rsp_ch.request_needed !== pending_results[0].request_needed) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("%0t: expected hit=%b mac=%h via=%b req=%b, got %b %h %b %b",
							$realtime, pending_results[0].hit, pending_results[0].mac_out,
							pending_results[0].via_router, pending_results[0].request_needed,
							rsp_ch.hit, rsp_ch.mac_out, rsp_ch.via_router,
							rsp_ch.request_needed);
				end
				void'(pending_results.pop_front());
			end
		end
	end

	// Result side ready: a new hold-off request from the test loads the counter,
	// otherwise stall at random.
	always @(posedge clk) begin
		if (hold_token != hold_taken) begin
			hold_taken = hold_token;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
		end
	end

	// Offer one request after a random gap, wait for the handshake, record its result.
	// Valid stays high after the handshake so back-to-back requests need no second write.
	task automatic send_request(input logic act, input logic [arpc_pkg::IP_W-1:0] ip,
			input logic [arpc_pkg::MAC_W-1:0] mac);
		if (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
			req_ch.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
		end
		req_ch.valid <= 1'b1;
		req_ch.action <= act;
		req_ch.ip_addr <= ip;
		req_ch.mac_addr <= mac;
		do @(posedge clk); while (!req_ch.ready);
		pending_results.push_back(predict_request(act, ip, mac));
	endtask

	// Drop valid, drain every owed result, then let the engine settle.
	task automatic wait_idle();
		req_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [arpc_pkg::CFG_IDX_W-1:0] idx,
			input logic [arpc_pkg::CFG_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			arpc_pkg::REG_LOCAL_ADDR: nb_local = data[arpc_pkg::IP_W-1:0];
			arpc_pkg::REG_SUBNET_MASK: nb_mask = data[arpc_pkg::IP_W-1:0];
			arpc_pkg::REG_ROUTER_MAC: nb_router = data[arpc_pkg::MAC_W-1:0];
			default: ;
		endcase
	endtask

	// Reprogram all registers while idle. Junk in the upper bits of the 32-bit
	// registers must be dropped, and a write to the spare index must change nothing.
	task automatic set_config(input logic [arpc_pkg::IP_W-1:0] own_addr,
			input logic [arpc_pkg::IP_W-1:0] mask, input logic [arpc_pkg::MAC_W-1:0] router);
		logic [15:0] junk_a;
		logic [15:0] junk_b;
		logic [arpc_pkg::CFG_W-1:0] junk_c;
		junk_a = 16'($urandom());
		junk_b = 16'($urandom());
		junk_c = arpc_pkg::CFG_W'({$urandom(), $urandom()});
		wait_idle();
		write_reg(arpc_pkg::REG_LOCAL_ADDR, {junk_a, own_addr});
		write_reg(arpc_pkg::REG_SUBNET_MASK, {junk_b, mask});
		write_reg(arpc_pkg::REG_ROUTER_MAC, router);
		write_reg(REG_UNUSED, junk_c);
	endtask

	// Hand-picked requests: extreme addresses, hits with zero MAC, removal by IP
	// and by MAC, off-subnet lookups, learning an off-subnet pair.
	task automatic test_directed();
		tx_idle_pct = 0;
		rx_stall_pct <= 0;
		// reset config: mask 0, so everything is on the subnet
		send_request(arpc_pkg::ACT_LOOKUP, 32'h0000_0000, 48'h0);
		send_request(arpc_pkg::ACT_LOOKUP, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
		send_request(arpc_pkg::ACT_LEARN, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
		send_request(arpc_pkg::ACT_LOOKUP, 32'hFFFF_FFFF, 48'h0);
		send_request(arpc_pkg::ACT_LEARN, 32'h0000_0000, 48'h0);
		send_request(arpc_pkg::ACT_LOOKUP, 32'h0000_0000, 48'h1234_5678_9ABC);
		// same MAC under a new IP evicts the old pair
		send_request(arpc_pkg::ACT_LEARN, 32'h0000_1234, 48'hFFFF_FFFF_FFFF);
		send_request(arpc_pkg::ACT_LOOKUP, 32'hFFFF_FFFF, 48'h0);
		send_request(arpc_pkg::ACT_LOOKUP, 32'h0000_1234, 48'h0);
		// same IP, new MAC
		send_request(arpc_pkg::ACT_LEARN, 32'h0000_1234, 48'hAAAA_AAAA_AAAA);
		send_request(arpc_pkg::ACT_LOOKUP, 32'h0000_1234, 48'h5555_5555_5555);
		// one learn that matches two entries, one by IP and one by MAC
		send_request(arpc_pkg::ACT_LEARN, 32'h0000_0000, 48'hAAAA_AAAA_AAAA);
		send_request(arpc_pkg::ACT_LOOKUP, 32'h0000_1234, 48'h0);
		send_request(arpc_pkg::ACT_LOOKUP, 32'h0000_0000, 48'h0);
		set_config(32'hC0A8_0101, 32'hFFFF_FF00, 48'hFFFF_FFFF_FFFF);
		send_request(arpc_pkg::ACT_LOOKUP, 32'h0A00_0001, 48'h0);
		send_request(arpc_pkg::ACT_LOOKUP, 32'hC0A8_01FF, 48'h0);
		send_request(arpc_pkg::ACT_LEARN, 32'h0808_0808, 48'h5555_5555_5555);
		// cached but off-subnet: the router still answers
		send_request(arpc_pkg::ACT_LOOKUP, 32'h0808_0808, 48'h0);
		send_request(arpc_pkg::ACT_LOOKUP, 32'hC0A8_0100, 48'h0);
		send_request(arpc_pkg::ACT_LOOKUP, 32'h0000_0000, 48'h0);
	endtask

	// Random traffic on a small pool of addresses so that hits, removals and
	// evictions are common; some off-subnet and fully random requests mixed in.
	task automatic test_random(input int tx_pct, input int rx_pct, input int count);
		logic act;
		logic [arpc_pkg::IP_W-1:0] ip;
		logic [arpc_pkg::IP_W-1:0] host;
		logic [arpc_pkg::IP_W-1:0] low_bit;
		logic [arpc_pkg::MAC_W-1:0] mac;
		int pick;
		tx_idle_pct = tx_pct;
		rx_stall_pct <= rx_pct;
		for (int n = 0; n < count; n++) begin
			act = ($urandom_range(99) < 45) ? arpc_pkg::ACT_LEARN : arpc_pkg::ACT_LOOKUP;
			host = $urandom_range(23);
			ip = (nb_local & nb_mask) | (host & ~nb_mask);
			pick = $urandom_range(99);
			if (pick >= 90) begin
				ip = $urandom();
			end else if (pick >= 76) begin
				// flip the lowest mask bit to leave the subnet
				low_bit = nb_mask & (~nb_mask + 1'b1);
				ip = ip ^ low_bit;
			end
			if ($urandom_range(99) < 70)
				mac = {16'h0200, 24'h0, 8'($urandom_range(29))};
			else
				mac = arpc_pkg::MAC_W'({$urandom(), $urandom()});
			send_request(act, ip, mac);
		end
	endtask

	// Fill the table past capacity, then remove from the middle and refill.
	task automatic test_table_full();
		tx_idle_pct = 20;
		rx_stall_pct <= 20;
		for (int i = 0; i <= ENTRIES; i++)
			send_request(arpc_pkg::ACT_LEARN, 32'h0A0A_0000 + i, 48'h0C00_0000_0000 + i);
		send_request(arpc_pkg::ACT_LOOKUP, 32'h0A0A_0000, 48'h0);
		send_request(arpc_pkg::ACT_LOOKUP, 32'h0A0A_0001, 48'h0);
		send_request(arpc_pkg::ACT_LEARN, 32'h0A0A_0005, 48'h0D00_0000_0005);
		send_request(arpc_pkg::ACT_LEARN, 32'h0A0A_0100, 48'h0D00_0000_0100);
		send_request(arpc_pkg::ACT_LEARN, 32'h0A0A_0101, 48'h0D00_0000_0101);
		send_request(arpc_pkg::ACT_LOOKUP, 32'h0A0A_0001, 48'h0);
		send_request(arpc_pkg::ACT_LOOKUP, 32'h0A0A_0005, 48'h0);
		send_request(arpc_pkg::ACT_LOOKUP, 32'h0A0A_0002, 48'h0);
	endtask

	// Hold the result side off for a long stretch while requests keep coming,
	// so the queue fills and the request side must stall.
	task automatic test_backpressure();
		tx_idle_pct = 0;
		rx_stall_pct <= 0;
		hold_token <= hold_token + 1;
		for (int i = 0; i < 20; i++) begin
			send_request(arpc_pkg::ACT_LEARN, 32'h0000_0040 + i, 48'h0E00_0000_0000 + i);
			send_request(arpc_pkg::ACT_LOOKUP, 32'h0000_0040 + i, 48'h0);
		end
	endtask

	// Upper bound on the run.
	initial begin
		#2_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		req_ch.valid = 1'b0;
		req_ch.action = arpc_pkg::ACT_LOOKUP;
		req_ch.ip_addr = '0;
		req_ch.mac_addr = '0;
		rsp_ch.ready = 1'b0;
		mismatch_count = 0;
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		hold_token = 0;
		hold_taken = 0;
		hold_left = 0;
		nb_local = '0;
		nb_mask = '0;
		nb_router = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			nb_valid[i] = 1'b0;
			nb_ip[i] = '0;
			nb_mac[i] = '0;
			nb_age[i] = 0;
		end
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_directed();

		set_config(32'hC0A8_0137, 32'hFFFF_FF00, 48'h0200_5E00_0001);
		test_random(0, 0, 200);
		set_config(32'h0A00_0000, 32'hFFFF_FFE0, 48'hFFFF_FFFF_FFFF);
		test_random(82, 0, 200);
		set_config($urandom(), 32'hFFFF_0000, arpc_pkg::MAC_W'({$urandom(), $urandom()}));
		test_random(0, 82, 200);
		set_config(32'h0000_0000, 32'h0000_0000, arpc_pkg::MAC_W'({$urandom(), $urandom()}));
		test_random(20, 20, 250);
		test_table_full();
		test_backpressure();
		set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 48'h0);
		test_random(20, 20, 100);

		wait_idle();
		if (mismatch_count == 0 && pending_results.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

[files.f]
rtl/arpc_pkg.sv
rtl/arpc_req_if.sv
rtl/arpc_rsp_if.sv
rtl/arpc_front.sv
rtl/arpc_queue.sv
rtl/arpc_back.sv
rtl/arp_neighbour_cache_core.sv
tb/arp_neighbour_cache_core_tb.sv
